### src/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

    // number of entries in the store
    localparam int ENTRIES = 16;
    // entry index and recency rank width
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // occupancy width, holds 0..ENTRIES
    localparam int OCC_W = $clog2(ENTRIES + 1);

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_CAPACITY = 1'b0;

    // operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    typedef logic [IDX_W-1:0] t_rank;
    typedef logic [OCC_W-1:0] t_occ;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } t_out_beat;

endpackage

`default_nettype wire

### src/lru_key_value_cache.sv
`default_nettype none

// channel    dir   handshake                 payload
// --------   ---   -----------------------   ------------------------------
// in         in    i_in_valid / o_in_stall   i_in_beat  (func, key, value)
// out        out   o_out_valid / i_out_stall o_out_beat (hit, read_value)
// config     in    apb psel/penable/pready   capacity at byte address 0
//
// one beat per cycle sustained unless a get waits on a stalled output: a beat is
// registered, then the key compare, recency update and store write happen when it
// is processed, and a get result is registered in the result register
// a set produces no result and never waits on the output side
// reset is synchronous, active low; it empties the store and sets capacity to 16
// a stalled output holds its result and stalls the input only when a get waits

module lru_key_value_cache (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire lkv_pkg::t_in_beat          i_in_beat,
    // result channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output lkv_pkg::t_out_beat              o_out_beat,
    // configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lkv_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lkv_pkg::DATA_W-1:0] pwdata,
    output logic      [lkv_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    // input register
    logic               r_in_valid;
    lkv_pkg::t_in_beat  r_in;
    // result register
    logic               r_out_valid;
    lkv_pkg::t_out_beat r_out;

    lkv_pkg::t_occ      w_eff_cap;
    lkv_pkg::t_out_beat w_result;
    logic               w_out_free;
    logic               w_is_get;
    logic               w_fire;
    logic               w_in_take;

    lkv_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_eff_cap (w_eff_cap)
    );

    // result slot is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_is_get   = (r_in.func == lkv_pkg::FUNC_GET);
    // the registered beat is processed when it has somewhere to go
    assign w_fire     = r_in_valid && (!w_is_get || w_out_free);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_in_take  = i_in_valid && !o_in_stall;

    lkv_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_item    (r_in),
        .i_eff_cap (w_eff_cap),
        .o_result  (w_result)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_beat;
        end
    end

    // result register control: a get loads it, a taken beat empties it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_is_get) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_is_get) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire

### src/lkv_regs.sv
`default_nettype none

module lkv_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lkv_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [lkv_pkg::DATA_W-1:0]       pwdata,
    output logic      [lkv_pkg::DATA_W-1:0]       prdata,
    output logic                                  pready,
    output lkv_pkg::t_occ                         o_eff_cap
);

    logic [lkv_pkg::CAP_W-1:0] r_capacity;
    logic                      w_sel_cap;

    assign w_sel_cap = (paddr[lkv_pkg::ADDR_W-1] == lkv_pkg::REG_CAPACITY);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkv_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && w_sel_cap) begin
            r_capacity <= pwdata[lkv_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_cap) begin
            prdata = lkv_pkg::DATA_W'(r_capacity);
        end
    end

    // zero acts as one, anything above the store size acts as the store size
    always_comb begin
        if (r_capacity == '0) begin
            o_eff_cap = lkv_pkg::OCC_W'(1);
        end else if (32'(r_capacity) > 32'(lkv_pkg::ENTRIES)) begin
            o_eff_cap = lkv_pkg::OCC_W'(lkv_pkg::ENTRIES);
        end else begin
            o_eff_cap = lkv_pkg::OCC_W'(r_capacity);
        end
    end

endmodule

`default_nettype wire

### src/lkv_store.sv
`default_nettype none

module lkv_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire lkv_pkg::t_in_beat i_item,
    input  wire lkv_pkg::t_occ     i_eff_cap,
    output lkv_pkg::t_out_beat     o_result
);

    localparam int N = lkv_pkg::ENTRIES;

    logic [lkv_pkg::KEY_W-1:0] r_key   [N];
    logic [lkv_pkg::VAL_W-1:0] r_value [N];
    logic [N-1:0]              r_valid;
    lkv_pkg::t_rank            r_rank  [N];
    lkv_pkg::t_occ             r_occ;

    logic [N-1:0]              w_match;
    logic [N-1:0]              w_lru;
    logic [N-1:0]              w_free;
    logic [N-1:0]              w_first_free;
    logic [N-1:0]              w_target;
    logic                      w_hit;
    logic                      w_full;
    logic                      w_is_set;
    logic                      w_insert;
    logic [lkv_pkg::VAL_W-1:0] w_hit_value;
    lkv_pkg::t_rank            w_hit_rank;
    lkv_pkg::t_rank            w_promote_rank;
    lkv_pkg::t_occ             w_last_rank;

    assign w_last_rank = r_occ - lkv_pkg::OCC_W'(1);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == i_item.key);
            w_lru[i]   = r_valid[i] && (lkv_pkg::OCC_W'(r_rank[i]) == w_last_rank);
        end
    end

    // keys are unique, so an and-or gather picks the single match
    always_comb begin
        w_hit_value = '0;
        w_hit_rank  = '0;
        for (int i = 0; i < N; i++) begin
            w_hit_value = w_hit_value | (r_value[i] & {lkv_pkg::VAL_W{w_match[i]}});
            w_hit_rank  = w_hit_rank  | (r_rank[i]  & {lkv_pkg::IDX_W{w_match[i]}});
        end
    end

    assign w_hit        = |w_match;
    assign w_full       = (r_occ >= i_eff_cap);
    assign w_is_set     = (i_item.func == lkv_pkg::FUNC_SET);
    assign w_free       = ~r_valid;
    assign w_first_free = w_free & (~w_free + N'(1));
    assign w_insert     = w_is_set && !w_hit && !w_full;

    always_comb begin
        if (w_hit) begin
            w_target       = w_match;
            w_promote_rank = w_hit_rank;
        end else if (w_full) begin
            w_target       = w_lru;
            w_promote_rank = lkv_pkg::IDX_W'(w_last_rank);
        end else begin
            w_target       = w_first_free;
            w_promote_rank = '0;
        end
    end

    assign o_result.hit        = w_hit;
    assign o_result.read_value = w_hit ? w_hit_value : lkv_pkg::MISS_VALUE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_fire && (w_is_set || w_hit)) begin
            for (int i = 0; i < N; i++) begin
                if (w_target[i]) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (w_insert || (r_rank[i] < w_promote_rank))) begin
                    r_rank[i] <= r_rank[i] + lkv_pkg::IDX_W'(1);
                end
            end
            if (w_insert) begin
                r_valid <= r_valid | w_target;
                r_occ   <= r_occ + lkv_pkg::OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && w_is_set) begin
            for (int i = 0; i < N; i++) begin
                if (w_target[i]) begin
                    r_key[i]   <= i_item.key;
                    r_value[i] <= i_item.value;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) == $countones(r_valid))
        else $error("occupancy does not match valid entries");

    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("key present in more than one entry");

    a_evict_keeps_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_is_set && !w_hit && w_full) |=> $stable(r_occ))
        else $error("eviction changed occupancy");

    a_lru_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != '0) |-> $onehot(w_lru))
        else $error("least recent entry not unique");
`endif

endmodule

`default_nettype wire
